/* hw/rtl/selective_repeat_receiver_core_defines.svh */
// Assertion macros shared by the selective-repeat receiver RTL.
// Each macro expects clk and rst to be visible in the module that uses it.
`ifndef SELECTIVE_REPEAT_RECEIVER_CORE_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SRR_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define SRR_ASSERT_NXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* hw/rtl/srr_pkg.sv */
// Shared types, codes and constants of the selective-repeat receiver.
// No dependencies; every other RTL file but the assertion macros header imports it.
package srr_pkg;

  localparam int SEQ_W  = 32;
  localparam int LEN_W  = 11;
  localparam int TAG_W  = 8;
  localparam int MODE_W = 2;
  localparam int KIND_W = 2;
  localparam int WIN_W  = 4;

  localparam int DEF_WINDOW_SLOTS = 8;
  localparam int MAX_PAYLOAD      = 1024;
  localparam int TAG_COUNT        = 256;
  localparam int MAX_RESULTS      = 8;
  localparam int RES_CNT_W        = $clog2(MAX_RESULTS + 1);

  localparam logic [WIN_W-1:0] WINDOW_SIZE_RESET = WIN_W'(8);

  // Received packet kinds
  localparam logic [MODE_W-1:0] MODE_DATA  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_EOF   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CRC   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_OTHER = 2'd3;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REJECT  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END_ACK = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd3;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] length;
    logic [TAG_W-1:0] tag;
  } slot_entry_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  acked_seq;
    logic [SEQ_W-1:0]  header_seq;
    logic [TAG_W-1:0]  deliver_tag;
    logic [LEN_W-1:0]  deliver_length;
    logic              last;
  } res_t;

  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_res_t;

endpackage

/* hw/rtl/srr_pkt_if.sv */
// Received packet channel: valid/ready plus the packet descriptor fields.
// Depends on srr_pkg.
interface srr_pkt_if import srr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [SEQ_W-1:0]  seq_number;
  logic [LEN_W-1:0]  payload_length;
  logic [TAG_W-1:0]  payload_tag;

  modport source (output valid, mode, seq_number, payload_length, payload_tag,
                  input ready);
  modport sink   (input valid, mode, seq_number, payload_length, payload_tag,
                  output ready);
endinterface

/* hw/rtl/srr_res_if.sv */
// Result channel: valid/ready plus the control packet / delivery fields.
// Depends on srr_pkg.
interface srr_res_if import srr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SEQ_W-1:0]  acked_seq;
  logic [SEQ_W-1:0]  header_seq;
  logic [TAG_W-1:0]  deliver_tag;
  logic [LEN_W-1:0]  deliver_length;
  logic              last;

  modport source (output valid, kind, acked_seq, header_seq, deliver_tag,
                  deliver_length, last, input ready);
  modport sink   (input valid, kind, acked_seq, header_seq, deliver_tag,
                  deliver_length, last, output ready);
endinterface

/* hw/rtl/srr_cfg_if.sv */
// Configuration write channel carrying the window size register.
// Depends on srr_pkg.
interface srr_cfg_if import srr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WIN_W-1:0] window_size;

  modport source (output valid, window_size, input ready);
  modport sink   (input valid, window_size, output ready);
endinterface

/* hw/rtl/srr_cmp_unit.sv */
// Shared 32-bit magnitude comparator used by the dispatch, store and drain steps.
// Depends on srr_pkg.
module srr_cmp_unit import srr_pkg::*; (
  input  logic [SEQ_W-1:0] a,
  input  logic [SEQ_W-1:0] b,
  output cmp_res_t         res
);

  // Unsigned equality and greater-than
  assign res.eq = (a == b);
  assign res.gt = (a > b);

endmodule

/* hw/rtl/srr_slot_mem.sv */
// Window slot descriptor memory: one write port, one registered read port.
// Depends on srr_pkg.
module srr_slot_mem import srr_pkg::*; #(
  parameter int DEPTH  = DEF_WINDOW_SLOTS,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  slot_entry_t       wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output slot_entry_t       rd_data
);

  slot_entry_t mem [DEPTH];

  // Write on request, read every cycle into the output register
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hw/rtl/srr_ctrl.sv */
// Sequencer of the selective-repeat receiver: dispatch, store scan, drain scan,
// result staging and the output register. Depends on srr_pkg, the channel
// interfaces and the assertion macros header.
`include "selective_repeat_receiver_core_defines.svh"

module srr_ctrl import srr_pkg::*; #(
  parameter int WINDOW_SLOTS = DEF_WINDOW_SLOTS,
  parameter int IDX_W        = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  srr_pkt_if.sink          pkt,
  srr_res_if.source        res,
  srr_cfg_if.sink          cfg,
  output logic [IDX_W-1:0] mem_rd_addr,
  input  slot_entry_t      mem_rd_data,
  output logic             mem_wr_en,
  output logic [IDX_W-1:0] mem_wr_addr,
  output slot_entry_t      mem_wr_data,
  output logic [SEQ_W-1:0] cmp_a,
  output logic [SEQ_W-1:0] cmp_b,
  input  cmp_res_t         cmp_res
);

  localparam int CNT_W = $clog2(WINDOW_SLOTS + 1);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DISPATCH = 3'd1;
  localparam logic [2:0] ST_STORE    = 3'd2;
  localparam logic [2:0] ST_PRIME    = 3'd3;
  localparam logic [2:0] ST_DRAIN    = 3'd4;
  localparam logic [2:0] ST_FLUSH    = 3'd5;

  logic [2:0]              state, state_next;
  logic [WIN_W-1:0]        window_size, window_size_next;
  logic                    finished, finished_next;
  logic [SEQ_W-1:0]        exp_num, exp_num_next;
  logic [SEQ_W-1:0]        send_num, send_num_next;
  logic [WINDOW_SLOTS-1:0] slot_full, slot_full_next;

  logic [MODE_W-1:0]       item_mode, item_mode_next;
  logic [SEQ_W-1:0]        item_seq, item_seq_next;
  logic [LEN_W-1:0]        item_len, item_len_next;
  logic [TAG_W-1:0]        item_tag, item_tag_next;

  logic                    drain_after, drain_after_next;
  logic [CNT_W-1:0]        idx, idx_next;
  logic                    dup, dup_next;
  logic                    free_found, free_found_next;
  logic [IDX_W-1:0]        free_idx, free_idx_next;
  logic [RES_CNT_W-1:0]    count, count_next;

  logic                    pend_valid, pend_valid_next;
  res_t                    pend, pend_next;
  logic                    out_valid, out_valid_next;
  res_t                    out, out_next;

  logic [CNT_W-1:0]        active_n;
  logic [IDX_W-1:0]        slot_i;
  logic                    out_free;
  logic                    drain_hit;

  // Effective window: smaller of the register and the slot count
  assign active_n = (int'(window_size) < WINDOW_SLOTS) ? CNT_W'(window_size)
                                                        : CNT_W'(WINDOW_SLOTS);
  assign slot_i   = idx[IDX_W-1:0];
  assign out_free = !out_valid || res.ready;

  assign pkt.ready   = (state == ST_IDLE) && !rst;
  assign cfg.ready   = !rst;
  assign mem_rd_addr = idx_next[IDX_W-1:0];

  assign res.valid          = out_valid;
  assign res.kind           = out.kind;
  assign res.acked_seq      = out.acked_seq;
  assign res.header_seq     = out.header_seq;
  assign res.deliver_tag    = out.deliver_tag;
  assign res.deliver_length = out.deliver_length;
  assign res.last           = out.last;

  // Next-state logic of the sequencer
  always_comb begin
    state_next       = state;
    window_size_next = window_size;
    finished_next    = finished;
    exp_num_next     = exp_num;
    send_num_next    = send_num;
    slot_full_next   = slot_full;
    item_mode_next   = item_mode;
    item_seq_next    = item_seq;
    item_len_next    = item_len;
    item_tag_next    = item_tag;
    drain_after_next = drain_after;
    idx_next         = idx;
    dup_next         = dup;
    free_found_next  = free_found;
    free_idx_next    = free_idx;
    count_next       = count;
    pend_valid_next  = pend_valid;
    pend_next        = pend;
    out_valid_next   = out_valid && !res.ready;
    out_next         = out;
    mem_wr_en        = 1'b0;
    mem_wr_addr      = free_idx;
    mem_wr_data      = '{seq: item_seq, length: item_len, tag: item_tag};
    cmp_a            = item_seq;
    cmp_b            = exp_num;
    drain_hit        = 1'b0;

    // Take a configuration write
    if (cfg.valid) begin
      window_size_next = cfg.window_size;
    end

    unique case (state)
      ST_IDLE: begin
        idx_next = '0;
        if (pkt.valid) begin
          item_mode_next = pkt.mode;
          item_seq_next  = pkt.seq_number;
          item_len_next  = (pkt.payload_length > LEN_W'(MAX_PAYLOAD)) ?
                           LEN_W'(MAX_PAYLOAD) : pkt.payload_length;
          item_tag_next  = TAG_W'(pkt.payload_tag % TAG_COUNT);
          state_next     = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        idx_next        = '0;
        dup_next        = 1'b0;
        free_found_next = 1'b0;
        if (finished || item_mode == MODE_CRC) begin
          state_next = ST_IDLE;
        end else if (item_mode == MODE_EOF) begin
          if (out_free) begin
            out_valid_next = 1'b1;
            out_next       = '{kind: KIND_END_ACK, acked_seq: '0, header_seq: send_num,
                               deliver_tag: '0, deliver_length: '0, last: 1'b1};
            finished_next  = 1'b1;
            state_next     = ST_IDLE;
          end
        end else if (item_mode == MODE_OTHER) begin
          if (out_free) begin
            out_valid_next = 1'b1;
            out_next       = '{kind: KIND_ERROR, acked_seq: '0, header_seq: '0,
                               deliver_tag: '0, deliver_length: '0, last: 1'b1};
            finished_next  = 1'b1;
            state_next     = ST_IDLE;
          end
        end else if (cmp_res.eq) begin
          drain_after_next = 1'b1;
          state_next       = ST_STORE;
        end else if (cmp_res.gt) begin
          // Reject the expected number, then buffer the early packet
          if (out_free) begin
            out_valid_next   = 1'b1;
            out_next         = '{kind: KIND_REJECT, acked_seq: exp_num,
                                 header_seq: send_num, deliver_tag: '0,
                                 deliver_length: '0, last: 1'b1};
            send_num_next    = send_num + SEQ_W'(1);
            drain_after_next = 1'b0;
            state_next       = ST_STORE;
          end
        end else begin
          // Old packet: drop
          state_next = ST_IDLE;
        end
      end

      ST_STORE: begin
        cmp_a = mem_rd_data.seq;
        cmp_b = item_seq;
        if (idx == active_n) begin
          // Commit into the first free slot unless the number is held already
          if (!dup && free_found) begin
            mem_wr_en                = 1'b1;
            slot_full_next[free_idx] = 1'b1;
          end
          idx_next   = '0;
          state_next = drain_after ? ST_PRIME : ST_IDLE;
        end else begin
          if (slot_full[slot_i] && cmp_res.eq) begin
            dup_next = 1'b1;
          end
          if (!slot_full[slot_i] && !free_found) begin
            free_found_next = 1'b1;
            free_idx_next   = slot_i;
          end
          idx_next = idx + CNT_W'(1);
        end
      end

      ST_PRIME: begin
        // Let the read register pick up slot zero after the write
        idx_next   = '0;
        count_next = '0;
        state_next = ST_DRAIN;
      end

      ST_DRAIN: begin
        cmp_a = mem_rd_data.seq;
        cmp_b = exp_num;
        if (idx == active_n || count == RES_CNT_W'(MAX_RESULTS)) begin
          idx_next   = '0;
          state_next = ST_FLUSH;
        end else if (slot_full[slot_i] && cmp_res.eq) begin
          if (pend_valid && !out_free) begin
            // Hold until the staged result can move out
            idx_next = idx;
          end else begin
            drain_hit = 1'b1;
            if (pend_valid) begin
              out_valid_next = 1'b1;
              out_next       = pend;
            end
            pend_valid_next        = 1'b1;
            pend_next              = '{kind: KIND_DELIVER, acked_seq: exp_num,
                                       header_seq: send_num,
                                       deliver_tag: mem_rd_data.tag,
                                       deliver_length: mem_rd_data.length,
                                       last: 1'b0};
            slot_full_next[slot_i] = 1'b0;
            exp_num_next           = exp_num + SEQ_W'(1);
            send_num_next          = send_num + SEQ_W'(1);
            count_next             = count + RES_CNT_W'(1);
            idx_next               = '0;
          end
        end else begin
          idx_next = idx + CNT_W'(1);
        end
      end

      ST_FLUSH: begin
        idx_next = '0;
        if (pend_valid) begin
          // Send the staged result as the last one of this item
          if (out_free) begin
            out_valid_next  = 1'b1;
            out_next        = pend;
            out_next.last   = 1'b1;
            pend_valid_next = 1'b0;
            state_next      = ST_IDLE;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      window_size <= WINDOW_SIZE_RESET;
      finished    <= 1'b0;
      exp_num     <= '0;
      send_num    <= '0;
      slot_full   <= '0;
      idx         <= '0;
      count       <= '0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
      dup         <= 1'b0;
      free_found  <= 1'b0;
      drain_after <= 1'b0;
    end else begin
      state       <= state_next;
      window_size <= window_size_next;
      finished    <= finished_next;
      exp_num     <= exp_num_next;
      send_num    <= send_num_next;
      slot_full   <= slot_full_next;
      idx         <= idx_next;
      count       <= count_next;
      pend_valid  <= pend_valid_next;
      out_valid   <= out_valid_next;
      dup         <= dup_next;
      free_found  <= free_found_next;
      drain_after <= drain_after_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_mode <= item_mode_next;
    item_seq  <= item_seq_next;
    item_len  <= item_len_next;
    item_tag  <= item_tag_next;
    free_idx  <= free_idx_next;
    pend      <= pend_next;
    out       <= out_next;
  end

  `SRR_ASSERT_IMP(a_pend_in_drain, pend_valid, (state == ST_DRAIN || state == ST_FLUSH), "staged result outside drain")
  `SRR_ASSERT_IMP(a_count_limit, state == ST_DRAIN, count <= RES_CNT_W'(MAX_RESULTS), "drain count over limit")
  `SRR_ASSERT_NXT(a_finished_sticky, finished, finished, "finished flag cleared without reset")
  `SRR_ASSERT_NXT(a_drain_advance, drain_hit, exp_num == $past(exp_num) + SEQ_W'(1), "expected number not advanced on drain")
  `SRR_ASSERT_IMP(a_write_in_store, mem_wr_en, (state == ST_STORE && !dup), "slot write outside store commit")

endmodule

/* hw/rtl/selective_repeat_receiver_core.sv */
// Selective-repeat ARQ receiver core (top level).
// Channels: pkt takes one received packet event per item (mode, sequence
// number, payload length, payload tag); res gives control/delivery results,
// with last set on the final result of each packet; cfg writes window_size.
// pkt is ready only while the sequencer is idle. Per packet: CRC errors, stale
// or post-stop packets are dropped; end of file and unknown flags give one
// result; an early packet gives a reject, then one store pass over the slots;
// an in-order packet takes a store pass, then the drain scan, which restarts at
// slot 0 after each delivery and stops after at most 8 deliveries. Each scan
// checks one slot a cycle on the one shared comparator, unless results stall.
// Results pass through a one-item output register, so a new packet is taken
// while a result still waits; deliveries are staged one deep to mark last.
// A stalled result sink holds the sequencer at its next result, and nothing
// is dropped. Reset (synchronous, active high) clears the sequence counters,
// every slot flag and the stop flag and sets window_size to 8; no clearing
// pass is needed. Depends on srr_pkg, the interfaces and the submodules.
module selective_repeat_receiver_core import srr_pkg::*; #(
  parameter int WINDOW_SLOTS = DEF_WINDOW_SLOTS
) (
  input  logic      clk,
  input  logic      rst,
  srr_pkt_if.sink   pkt,
  srr_res_if.source res,
  srr_cfg_if.sink   cfg
);

  localparam int IDX_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;

  logic [IDX_W-1:0] mem_rd_addr;
  slot_entry_t      mem_rd_data;
  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  slot_entry_t      mem_wr_data;
  logic [SEQ_W-1:0] cmp_a;
  logic [SEQ_W-1:0] cmp_b;
  cmp_res_t         cmp_res;

  // Sequencer
  srr_ctrl #(
    .WINDOW_SLOTS (WINDOW_SLOTS),
    .IDX_W        (IDX_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pkt         (pkt),
    .res         (res),
    .cfg         (cfg),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .cmp_a       (cmp_a),
    .cmp_b       (cmp_b),
    .cmp_res     (cmp_res)
  );

  // Slot descriptor memory
  srr_slot_mem #(
    .DEPTH  (WINDOW_SLOTS),
    .ADDR_W (IDX_W)
  ) u_slot_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Shared comparator
  srr_cmp_unit u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp_res)
  );

endmodule
